FILE: rtl/core/tfq_pkg.sv
// Package for the telemetry frame queue: operation and status codes, controller states,
// controller/datapath command and status structs, and the fixed field widths.
// Depends on nothing; used by every module of the block.
`default_nettype none

package tfq_pkg;

	localparam int QUEUE_SLOTS_DEF = 16;
	localparam int CHANNELS        = 6;
	localparam int WORD_W          = 32;
	localparam int OP_W            = 2;
	localparam int PEND_W          = 4;
	localparam int WIDX_W          = 3;
	localparam int S_DATA_W        = 200;
	localparam int M_DATA_W        = 72;

	localparam logic [WORD_W-1:0] TAIL_MARKER = 32'h7F80_0000;
	localparam logic [WIDX_W-1:0] LAST_WIDX   = WIDX_W'(CHANNELS);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 2'd0,
		OP_SEND = 2'd1,
		OP_DONE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_DROPPED = 2'd1,
		ST_NOTHING = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		S_IDLE = 1'b0,
		S_EMIT = 1'b1
	} state_t;

	typedef logic [CHANNELS-1:0][WORD_W-1:0] frame_t;

	typedef struct packed {
		logic accept;
		logic emit_word;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic send_ok;
		logic word_last;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/tfq_ctrl.sv
// Controller of the telemetry frame queue: sequences item acceptance and frame emission.
// Depends on tfq_pkg; drives the datapath through tfq_pkg::cmd_t.
`default_nettype none

module tfq_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire  [tfq_pkg::OP_W-1:0]     in_op,
	output logic                         in_ready,
	input  tfq_pkg::sts_t                sts,
	output tfq_pkg::cmd_t                cmd
);

	tfq_pkg::state_t state_q;
	tfq_pkg::state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfq_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n       = state_q;
		in_ready      = 1'b0;
		cmd.accept    = 1'b0;
		cmd.emit_word = 1'b0;
		unique case (state_q)
			tfq_pkg::S_IDLE: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					cmd.accept = 1'b1;
					if (in_op == tfq_pkg::OP_SEND && sts.send_ok) begin
						state_n = tfq_pkg::S_EMIT;
					end
				end
			end
			tfq_pkg::S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_word = 1'b1;
					if (sts.word_last) begin
						state_n = tfq_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_n = tfq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/tfq_datapath.sv
// Datapath of the telemetry frame queue: frame store, ring pointers, overflow counter,
// busy flag, word sequencer and output register. Depends on tfq_pkg.
`default_nettype none

module tfq_datapath #(
	parameter int QUEUE_SLOTS = tfq_pkg::QUEUE_SLOTS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  [tfq_pkg::OP_W-1:0]         in_op,
	input  wire  [tfq_pkg::S_DATA_W-1:0]     in_data,
	input  tfq_pkg::cmd_t                    cmd,
	output tfq_pkg::sts_t                    sts,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [tfq_pkg::M_DATA_W-1:0]     out_data,
	output logic                             out_last,
	output logic                             out_is_word
);

	localparam int PTR_W = $clog2(QUEUE_SLOTS);

	tfq_pkg::frame_t mem_q [QUEUE_SLOTS];
	tfq_pkg::frame_t row_q;
	tfq_pkg::frame_t row_in;

	logic [PTR_W-1:0] head_q, tail_q, head_n, tail_n, head_adv, tail_adv;
	logic [tfq_pkg::WORD_W-1:0] ovf_q, ovf_n;
	logic busy_q, busy_n;
	logic [tfq_pkg::WIDX_W-1:0] widx_q;
	logic link_ready, empty, full, send_go, wr_en;
	tfq_pkg::status_t res_status;
	logic [PTR_W:0] span;
	logic [PTR_W+4:0] span_ext;
	logic [tfq_pkg::PEND_W-1:0] pending;
	logic [tfq_pkg::WORD_W-1:0] word_sel;

	logic out_valid_q, last_q, is_word_q;
	logic [tfq_pkg::WORD_W-1:0] word_q, ovf_out_q;
	tfq_pkg::status_t status_q;
	logic [tfq_pkg::PEND_W-1:0] pending_q;
	logic busy_out_q;
	logic load_res;

	assign row_in     = in_data[tfq_pkg::CHANNELS*tfq_pkg::WORD_W-1:0];
	assign link_ready = in_data[tfq_pkg::CHANNELS*tfq_pkg::WORD_W];

	assign head_adv = (head_q == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : head_q + 1'b1;
	assign tail_adv = (tail_q == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : tail_q + 1'b1;
	assign empty    = (head_q == tail_q);
	assign full     = (head_adv == tail_q);

	always_comb begin
		head_n     = head_q;
		tail_n     = tail_q;
		ovf_n      = ovf_q;
		busy_n     = busy_q;
		send_go    = 1'b0;
		wr_en      = 1'b0;
		res_status = tfq_pkg::ST_NOTHING;
		if (cmd.accept) begin
			unique case (in_op)
				tfq_pkg::OP_PUSH: begin
					if (full) begin
						ovf_n      = ovf_q + 1'b1;
						res_status = tfq_pkg::ST_DROPPED;
					end else begin
						wr_en      = 1'b1;
						head_n     = head_adv;
						res_status = tfq_pkg::ST_DONE;
					end
				end
				tfq_pkg::OP_SEND: begin
					if (!busy_q && !empty && link_ready) begin
						busy_n  = 1'b1;
						send_go = 1'b1;
					end
				end
				tfq_pkg::OP_DONE: begin
					if (!empty) begin
						tail_n     = tail_adv;
						res_status = tfq_pkg::ST_DONE;
					end
					busy_n = 1'b0;
				end
				default: begin
					res_status = tfq_pkg::ST_NOTHING;
				end
			endcase
		end
	end

	always_comb begin
		span = {1'b0, head_n} - {1'b0, tail_n};
		if (head_n < tail_n) begin
			span = span + (PTR_W+1)'(QUEUE_SLOTS);
		end
		span_ext = (PTR_W+5)'(span);
		pending  = (span_ext > (PTR_W+5)'(15)) ? 4'd15 : span_ext[tfq_pkg::PEND_W-1:0];
	end

	assign word_sel = (widx_q == tfq_pkg::LAST_WIDX) ? tfq_pkg::TAIL_MARKER : row_q[widx_q];

	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.send_ok   = !busy_q && !empty && link_ready;
	assign sts.word_last = (widx_q == tfq_pkg::LAST_WIDX);

	assign load_res = cmd.accept && !send_go;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[head_q] <= row_in;
		end
		if (send_go) begin
			row_q <= mem_q[tail_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			ovf_q       <= '0;
			busy_q      <= 1'b0;
			widx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			head_q <= head_n;
			tail_q <= tail_n;
			ovf_q  <= ovf_n;
			busy_q <= busy_n;
			if (send_go) begin
				widx_q <= '0;
			end else if (cmd.emit_word) begin
				widx_q <= widx_q + 1'b1;
			end
			if (load_res || cmd.emit_word) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			is_word_q  <= 1'b0;
			word_q     <= '0;
			last_q     <= 1'b1;
			status_q   <= res_status;
			pending_q  <= pending;
			ovf_out_q  <= ovf_n;
			busy_out_q <= busy_n;
		end else if (cmd.emit_word) begin
			is_word_q  <= 1'b1;
			word_q     <= word_sel;
			last_q     <= sts.word_last;
			status_q   <= tfq_pkg::ST_DONE;
			pending_q  <= pending;
			ovf_out_q  <= ovf_q;
			busy_out_q <= busy_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_last    = last_q;
	assign out_is_word = is_word_q;
	assign out_data    = {1'b0, busy_out_q, ovf_out_q, pending_q, status_q, word_q};

endmodule

`default_nettype wire

FILE: rtl/core/telemetry_frame_queue.sv
// Top level of the telemetry frame queue: a ring of frames sent out as seven-word bursts.
// Depends on tfq_pkg, tfq_ctrl and tfq_datapath.
//
//   Channel   Dir  tdata                                      tuser           tlast
//   s_axis    in   chan_one..chan_six, link_ready             operation       -
//   m_axis    out  frame_word, status, pending, overflow,     is_frame_word   last
//                  busy_res
//
// A push, a completion or a refused send is accepted and its beat is ready the next cycle.
// After the frame row is read, a successful send gives seven beats, one per cycle unless
// stalled, paced by the single output register and the word sequencer; no item is taken meanwhile.
// Reset clears pointers, overflow counter and busy flag; the frame store is not cleared.
// A stalled output holds its beat and closes the input until the register is freed.
`default_nettype none

module telemetry_frame_queue #(
	parameter int QUEUE_SLOTS = tfq_pkg::QUEUE_SLOTS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	// chan_one [31:0] .. chan_six [191:160], link_ready [192], zero padding above.
	input  wire  [tfq_pkg::S_DATA_W-1:0]     s_axis_tdata,
	// operation [1:0].
	input  wire  [tfq_pkg::OP_W-1:0]         s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// frame_word [31:0], status [33:32], pending [37:34], overflow_count [69:38],
	// busy_res [70], zero padding [71].
	output logic [tfq_pkg::M_DATA_W-1:0]     m_axis_tdata,
	// is_frame_word [0].
	output logic                             m_axis_tuser,
	output logic                             m_axis_tlast
);

	tfq_pkg::cmd_t cmd;
	tfq_pkg::sts_t sts;

	tfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tfq_datapath #(
		.QUEUE_SLOTS (QUEUE_SLOTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_op       (s_axis_tuser),
		.in_data     (s_axis_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.out_last    (m_axis_tlast),
		.out_is_word (m_axis_tuser)
	);

endmodule

`default_nettype wire
